[rtl/cdsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cdsa_pkg;

  // Stream payload layout
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned LoadYearLsb  = 0;
  localparam int unsigned LoadMonthLsb = 14;
  localparam int unsigned LoadDayLsb   = 18;
  localparam int unsigned SpanYearsLsb = 23;
  localparam int unsigned SpanMonLsb   = 38;
  localparam int unsigned SpanDaysLsb  = 51;

  // Date held after reset: January 1, 1970
  localparam logic [13:0] ResetYear  = 14'd1970;
  localparam logic [3:0]  ResetMonth = 4'd0;
  localparam logic [4:0]  ResetDay   = 5'd1;

  localparam logic [15:0] MaxYear = 16'd9999;

  // Reciprocal constants for division by 12, 400 and 100
  localparam logic [16:0] MonRecip   = 17'd43691;
  localparam int unsigned MonShift   = 19;
  localparam logic [13:0] MonOffset  = 14'd4104;   // 342 * 12
  localparam logic [15:0] MonYearAdj = 16'd342;
  localparam logic [16:0] YrRecip    = 17'd83887;
  localparam int unsigned YrShift    = 25;
  localparam logic [15:0] YrOffset   = 16'd17200;  // 43 * 400
  localparam logic [16:0] CentRecip  = 17'd5243;
  localparam int unsigned CentShift  = 19;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MON_MUL,
    OP_MON_SPLIT,
    OP_YR_MUL,
    OP_YR_MOD,
    OP_CHECK,
    OP_CLAMP,
    OP_WALK,
    OP_RANGE,
    OP_WK_MUL,
    OP_WK_DIV,
    OP_WK_TERMS,
    OP_WK_MOD,
    OP_WK_SUM,
    OP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_stat_t;

  // Leap test on the year reduced mod 400
  function automatic logic is_leap(input logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd30;
      4'd5:    n = 5'd30;
      4'd8:    n = 5'd30;
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Days from March 1 to the first of the month, mod 7, by calendar month
  function automatic logic [2:0] month_term7(input logic [3:0] m);
    logic [2:0] t;
    case (m)
      4'd0:    t = 3'd5;
      4'd1:    t = 3'd1;
      4'd2:    t = 3'd0;
      4'd3:    t = 3'd3;
      4'd4:    t = 3'd5;
      4'd5:    t = 3'd1;
      4'd6:    t = 3'd3;
      4'd7:    t = 3'd6;
      4'd8:    t = 3'd2;
      4'd9:    t = 3'd4;
      4'd10:   t = 3'd0;
      default: t = 3'd2;
    endcase
    return t;
  endfunction

  // Residue mod 7 by summing octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [26:0] v);
    logic [5:0] s;
    logic [3:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < 9; i++) begin
      s = s + 6'(v[3*i +: 3]);
    end
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

[rtl/cdsa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdsa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  input  wire logic               s_tkind_i,
  output logic                    s_tready_o,
  input  wire logic               m_tready_i,
  output logic                    m_tvalid_o,
  input  wire cdsa_pkg::dp_stat_t stat_i,
  output cdsa_pkg::dp_cmd_t       cmd_o
);
  import cdsa_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_MON_MUL  = 15'b000000000000010,
    ST_MON_SPLT = 15'b000000000000100,
    ST_YR_MUL   = 15'b000000000001000,
    ST_YR_MOD   = 15'b000000000010000,
    ST_CHECK    = 15'b000000000100000,
    ST_CLAMP    = 15'b000000001000000,
    ST_WALK     = 15'b000000010000000,
    ST_RANGE    = 15'b000000100000000,
    ST_WK_MUL   = 15'b000001000000000,
    ST_WK_DIV   = 15'b000010000000000,
    ST_WK_TERMS = 15'b000100000000000,
    ST_WK_MOD   = 15'b001000000000000,
    ST_WK_SUM   = 15'b010000000000000,
    ST_OUT      = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   add_q, add_d;
  logic   m_valid_q, m_valid_d;
  logic   out_load;

  always_comb begin
    state_d    = state_q;
    add_d      = add_q;
    cmd_o.op   = OP_NONE;
    s_tready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = OP_CAPTURE;
          add_d    = s_tkind_i;
          state_d  = s_tkind_i ? ST_MON_MUL : ST_YR_MUL;
        end
      end
      ST_MON_MUL: begin
        cmd_o.op = OP_MON_MUL;
        state_d  = ST_MON_SPLT;
      end
      ST_MON_SPLT: begin
        cmd_o.op = OP_MON_SPLIT;
        state_d  = ST_YR_MUL;
      end
      ST_YR_MUL: begin
        cmd_o.op = OP_YR_MUL;
        state_d  = ST_YR_MOD;
      end
      ST_YR_MOD: begin
        cmd_o.op = OP_YR_MOD;
        state_d  = add_q ? ST_CLAMP : ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = ST_WK_MUL;
      end
      ST_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        // one month boundary per cycle until the day fits its month
        cmd_o.op = OP_WALK;
        if (stat_i.walk_done) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.op = OP_RANGE;
        state_d  = ST_WK_MUL;
      end
      ST_WK_MUL: begin
        cmd_o.op = OP_WK_MUL;
        state_d  = ST_WK_DIV;
      end
      ST_WK_DIV: begin
        cmd_o.op = OP_WK_DIV;
        state_d  = ST_WK_TERMS;
      end
      ST_WK_TERMS: begin
        cmd_o.op = OP_WK_TERMS;
        state_d  = ST_WK_MOD;
      end
      ST_WK_MOD: begin
        cmd_o.op = OP_WK_MOD;
        state_d  = ST_WK_SUM;
      end
      ST_WK_SUM: begin
        cmd_o.op = OP_WK_SUM;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_tready_i) begin
          cmd_o.op = OP_OUT_LOAD;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign m_tvalid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      add_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      add_q     <= add_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cdsa_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdsa_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cdsa_pkg::dp_cmd_t             cmd_i,
  output cdsa_pkg::dp_stat_t                 stat_o,
  input  wire logic                          s_tkind_i,
  input  wire logic [cdsa_pkg::InDataW-1:0]  s_tdata_i,
  output logic      [cdsa_pkg::OutDataW-1:0] m_tdata_o,
  output logic                               m_terr_o
);
  import cdsa_pkg::*;

  // committed date
  logic [13:0] cur_year_q;
  logic [3:0]  cur_month_q;
  logic [4:0]  cur_day_q;

  // working registers
  logic [15:0] y_q;       // two's complement year while adding
  logic [3:0]  m_q;
  logic [4:0]  ld_q;
  logic [16:0] sd_q;
  logic [13:0] u_q;       // month sum plus offset, kept non-negative
  logic [32:0] prod_q;
  logic [8:0]  ymod_q;    // year mod 400, floored
  logic [17:0] acc_q;     // two's complement day count
  logic        err_q;
  logic [7:0]  c_q;
  logic [6:0]  r_q;
  logic [24:0] t1_q;
  logic [2:0]  a7_q;
  logic [2:0]  b7_q;
  logic [2:0]  wd_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_err_q;

  // input fields
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [14:0] in_sy;
  logic [12:0] in_sm;
  logic [16:0] in_sd;

  assign in_year  = s_tdata_i[LoadYearLsb  +: 14];
  assign in_month = s_tdata_i[LoadMonthLsb +: 4];
  assign in_day   = s_tdata_i[LoadDayLsb   +: 5];
  assign in_sy    = s_tdata_i[SpanYearsLsb +: 15];
  assign in_sm    = s_tdata_i[SpanMonLsb   +: 13];
  assign in_sd    = s_tdata_i[SpanDaysLsb  +: 17];

  // shared constant multiplier
  logic [15:0] yb;
  logic [14:0] yy;
  logic [15:0] mul_a;
  logic [16:0] mul_k;
  logic [32:0] mul_p;

  assign yb = y_q + YrOffset;
  assign yy = 15'(cur_year_q) + 15'd4800 - 15'(cur_month_q < 4'd2);

  always_comb begin
    mul_a = yb;
    mul_k = YrRecip;
    case (cmd_i.op)
      OP_MON_MUL: begin
        mul_a = 16'(u_q);
        mul_k = MonRecip;
      end
      OP_WK_MUL: begin
        mul_a = 16'(yy);
        mul_k = CentRecip;
      end
      default: ;
    endcase
  end

  assign mul_p = 33'(mul_a) * 33'(mul_k);

  // month split and year mod 400
  logic [9:0]  mon_q10;
  logic [7:0]  yr_q8;
  logic [3:0]  mon_rem;
  logic [8:0]  ymod_new;

  assign mon_q10  = prod_q[MonShift +: 10];
  assign mon_rem  = 4'(u_q - 14'(mon_q10) * 14'd12);
  assign yr_q8    = prod_q[YrShift +: 8];
  assign ymod_new = 9'(yb - 16'(yr_q8) * 16'd400);

  // month walk
  logic       leap_cur;
  logic [4:0] dim_cur;
  logic [3:0] m_prev;
  logic [8:0] ymod_prev;
  logic [4:0] dim_prev;
  logic [8:0] ymod_next;
  logic [3:0] m_next;
  logic       walk_back;
  logic       walk_fwd;
  logic [4:0] day_clamp;
  logic       load_bad;
  logic       year_bad;

  assign leap_cur  = is_leap(ymod_q);
  assign dim_cur   = days_in(m_q, leap_cur);
  assign m_prev    = (m_q == 4'd0) ? 4'd11 : m_q - 4'd1;
  assign ymod_prev = (m_q != 4'd0) ? ymod_q :
                     ((ymod_q == 9'd0) ? 9'd399 : ymod_q - 9'd1);
  assign dim_prev  = days_in(m_prev, is_leap(ymod_prev));
  assign m_next    = (m_q == 4'd11) ? 4'd0 : m_q + 4'd1;
  assign ymod_next = (m_q != 4'd11) ? ymod_q :
                     ((ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1);

  assign walk_back = acc_q[17] || (acc_q == 18'd0);
  assign walk_fwd  = !acc_q[17] && (acc_q[16:0] > 17'(dim_cur));
  assign stat_o.walk_done = !walk_back && !walk_fwd;

  assign day_clamp = (cur_day_q > dim_cur) ? dim_cur : cur_day_q;

  assign load_bad = (y_q == 16'd0) || (y_q > MaxYear) || (m_q > 4'd11) ||
                    (ld_q == 5'd0) || (ld_q > dim_cur);
  assign year_bad = y_q[15] || (y_q == 16'd0) || (y_q > MaxYear);

  // weekday terms
  logic [17:0] t2;
  assign t2 = 18'(r_q) * 18'd1461;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= ResetYear;
      cur_month_q <= ResetMonth;
      cur_day_q   <= ResetDay;
    end else begin
      if (cmd_i.op == OP_CHECK && !load_bad) begin
        cur_year_q  <= y_q[13:0];
        cur_month_q <= m_q;
        cur_day_q   <= ld_q;
      end else if (cmd_i.op == OP_RANGE && !year_bad) begin
        cur_year_q  <= y_q[13:0];
        cur_month_q <= m_q;
        cur_day_q   <= acc_q[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_CAPTURE: begin
        if (s_tkind_i) begin
          y_q <= 16'(cur_year_q) + {in_sy[14], in_sy};
        end else begin
          y_q <= 16'(in_year);
        end
        m_q  <= in_month;
        ld_q <= in_day;
        sd_q <= in_sd;
        u_q  <= 14'(cur_month_q) + {in_sm[12], in_sm} + MonOffset;
      end
      OP_MON_MUL, OP_YR_MUL, OP_WK_MUL: begin
        prod_q <= mul_p;
      end
      OP_MON_SPLIT: begin
        m_q <= mon_rem;
        y_q <= y_q + 16'(mon_q10) - MonYearAdj;
      end
      OP_YR_MOD: begin
        ymod_q <= ymod_new;
      end
      OP_CHECK: begin
        err_q <= load_bad;
      end
      OP_CLAMP: begin
        acc_q <= {sd_q[16], sd_q} + 18'(day_clamp);
      end
      OP_WALK: begin
        if (walk_back) begin
          // step back into the previous month
          m_q    <= m_prev;
          ymod_q <= ymod_prev;
          acc_q  <= acc_q + 18'(dim_prev);
          if (m_q == 4'd0) begin
            y_q <= y_q - 16'd1;
          end
        end else if (walk_fwd) begin
          // drop the current month and advance
          m_q    <= m_next;
          ymod_q <= ymod_next;
          acc_q  <= acc_q - 18'(dim_cur);
          if (m_q == 4'd11) begin
            y_q <= y_q + 16'd1;
          end
        end
      end
      OP_RANGE: begin
        err_q <= year_bad;
      end
      OP_WK_DIV: begin
        c_q <= prod_q[CentShift +: 8];
      end
      OP_WK_TERMS: begin
        r_q  <= 7'(yy - 15'(c_q) * 15'd100);
        t1_q <= 25'(c_q) * 25'd146097;
      end
      OP_WK_MOD: begin
        a7_q <= mod7(27'(t1_q[24:2]));
        b7_q <= mod7(27'(t2[17:2]));
      end
      OP_WK_SUM: begin
        // the constant 2 folds in the epoch offset and the weekday shift
        wd_q <= mod7(27'(a7_q) + 27'(b7_q) + 27'(month_term7(cur_month_q)) +
                     27'(cur_day_q) + 27'd2);
      end
      OP_OUT_LOAD: begin
        out_data_q <= {(OutDataW - 26)'(0), wd_q, cur_day_q, cur_month_q, cur_year_q};
        out_err_q  <= err_q;
      end
      default: ;
    endcase
  end

  assign m_tdata_o = out_data_q;
  assign m_terr_o  = out_err_q;

endmodule

`default_nettype wire

[rtl/calendar_date_span_adder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date register with span adder. A transaction with tuser low loads
// the date after validating it; with tuser high it adds years, then months
// with year carry, clamps the day to the month length and then adds the
// signed day count. Each transaction returns one result: the date, its
// weekday (0 is Sunday) and, in tuser, an error flag; on error the date is
// unchanged. An add walks the day count one month boundary per cycle, and all
// divisions share one constant multiplier. Results wait in an output
// register, so the next transaction is accepted while the previous result is
// still pending.
module calendar_date_span_adder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // load_year[13:0], load_month[17:14], load_day[22:18], span_years[37:23],
  // span_months[50:38], span_days[67:51], zero pad [71:68]
  input  wire logic [cdsa_pkg::InDataW-1:0]  s_axis_tdata,
  // kind: 0 load, 1 add
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // date_year[13:0], date_month[17:14], date_day[22:18], weekday[25:23],
  // zero pad [31:26]
  output logic      [cdsa_pkg::OutDataW-1:0] m_axis_tdata,
  // error
  output logic                               m_axis_tuser
);
  import cdsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cdsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tkind_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cdsa_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .s_tkind_i (s_axis_tuser),
    .s_tdata_i (s_axis_tdata),
    .m_tdata_o (m_axis_tdata),
    .m_terr_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[test/tb_calendar_date_span_adder_unit.sv]
`timescale 1ns / 1ps

module tb_calendar_date_span_adder_unit;

  localparam logic KindLoad = 1'b0;
  localparam logic KindAdd  = 1'b1;

  localparam int NumDirected = 27;
  localparam int NumRandom   = 1280;
  localparam int QuietLimit  = 20000;

  typedef struct packed {
    logic               kind;
    logic [13:0]        ld_year;
    logic [3:0]         ld_month;
    logic [4:0]         ld_day;
    logic signed [14:0] sp_years;
    logic signed [12:0] sp_months;
    logic signed [16:0] sp_days;
  } date_op_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic        err;
  } date_res_t;

  typedef struct packed {
    date_op_t  op;
    logic      typed;
    date_res_t res;
  } plan_row_t;

  localparam date_res_t NoRes       = '{14'd0, 4'd0, 5'd0, 3'd0, 1'b0};
  localparam date_res_t EpochRes    = '{14'd1970, 4'd0, 5'd1, 3'd4, 1'b0};
  localparam date_res_t LastDayRes  = '{14'd9999, 4'd11, 5'd31, 3'd5, 1'b0};
  localparam date_res_t LastDayErr  = '{14'd9999, 4'd11, 5'd31, 3'd5, 1'b1};
  localparam date_res_t FirstDayRes = '{14'd1, 4'd0, 5'd1, 3'd1, 1'b0};
  localparam date_res_t FirstDayErr = '{14'd1, 4'd0, 5'd1, 3'd1, 1'b1};

  // Directed rows; the expectation is typed in only where it is obvious
  localparam plan_row_t DirPlan [NumDirected] = '{
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd0,   17'sd0},     1'b1, EpochRes},
    '{'{KindLoad, 14'd9999,  4'd11, 5'd31, 15'sd0,     13'sd0,   17'sd0},     1'b1, LastDayRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd0,   17'sd1},     1'b1, LastDayErr},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd16383, 13'sd0,   17'sd0},     1'b1, LastDayErr},
    '{'{KindLoad, 14'd1,     4'd0,  5'd1,  15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd0,   -17'sd1},    1'b1, FirstDayErr},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'h4000,   13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'd1970,  4'd12, 5'd1,  15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'd1970,  4'd0,  5'd0,  15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'd0,     4'd0,  5'd1,  15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'h3fff,  4'hf,  5'h1f, 15'h7fff,   13'h1fff, 17'h1ffff},  1'b1, FirstDayErr},
    '{'{KindLoad, 14'd2023,  4'd1,  5'd29, 15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'd1900,  4'd1,  5'd29, 15'sd0,     13'sd0,   17'sd0},     1'b1, FirstDayErr},
    '{'{KindLoad, 14'd2000,  4'd1,  5'd29, 15'sd0,     13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindLoad, 14'd2024,  4'd0,  5'd31, 15'sd0,     13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd1,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     -13'sd13, 17'sd0},     1'b0, NoRes},
    '{'{KindLoad, 14'd1900,  4'd1,  5'd28, 15'sd0,     13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd0,   17'sd1},     1'b0, NoRes},
    '{'{KindLoad, 14'd5000,  4'd5,  5'd15, 15'sd0,     13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd4999,  13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  -15'sd9999, 13'sd0,   17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'h1000, 17'sd0},     1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd4095, 17'sd0},    1'b0, NoRes},
    '{'{KindLoad, 14'd2000,  4'd0,  5'd1,  15'sd0,     13'sd0,   17'sd65535}, 1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  15'sd0,     13'sd0,   17'sd65535}, 1'b0, NoRes},
    '{'{KindAdd,  14'd0,     4'd0,  5'd0,  -15'sd10,   13'sd0,   17'h10000},  1'b0, NoRes}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [cdsa_pkg::InDataW-1:0]    s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [cdsa_pkg::OutDataW-1:0]   m_axis_tdata;
  logic                            m_axis_tuser;

  date_res_t expected_dates [$];

  int cal_year;
  int cal_month;
  int cal_day;

  bit no_idle;
  int n_fail;
  int n_loads;
  int n_adds;
  int n_checked;
  int n_rejects;

  calendar_date_span_adder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(int y, int m);
    if (m < 0 || m > 11) return 31;
    if (m == 1) return leap_year(y) ? 29 : 28;
    if (m == 3 || m == 5 || m == 8 || m == 10) return 30;
    return 31;
  endfunction

  // Count the year from March so that February ends it
  function automatic logic [2:0] day_of_week(int y, int m, int d);
    int yy;
    int mm;
    int jdn;
    yy = y + 4800;
    mm = m - 2;
    if (m < 2) begin
      mm = m + 10;
      yy = yy - 1;
    end
    jdn = ((yy / 100) * 146097) / 4 + ((yy % 100) * 1461) / 4
        + (mm * 153 + 2) / 5 + d - 32046;
    return 3'((jdn + 2) % 7);
  endfunction

  function automatic date_res_t advance_date(date_op_t op);
    int y;
    int m;
    int d;
    int t;
    int q;
    int sy;
    int sm;
    int sd;
    bit bad;
    date_res_t r;
    bad = 1'b0;
    if (op.kind == KindLoad) begin
      y = op.ld_year;
      m = op.ld_month;
      d = op.ld_day;
      if (y < 1 || y > 9999 || m > 11 || d < 1 || d > month_days(y, m)) begin
        bad = 1'b1;
      end else begin
        cal_year  = y;
        cal_month = m;
        cal_day   = d;
      end
    end else begin
      sy = op.sp_years;
      sm = op.sp_months;
      sd = op.sp_days;
      y = cal_year + sy;
      t = cal_month + sm;
      q = (t >= 0) ? (t / 12) : -((11 - t) / 12);
      y = y + q;
      m = t - q * 12;
      d = cal_day;
      if (d > month_days(y, m)) d = month_days(y, m);
      // borrow whole months until the day count lands inside one
      while (sd + d < 1) begin
        m--;
        if (m < 0) begin
          m = 11;
          y--;
        end
        sd += month_days(y, m);
      end
      d += sd;
      while (d > month_days(y, m)) begin
        d -= month_days(y, m);
        m++;
        if (m > 11) begin
          m = 0;
          y++;
        end
      end
      if (y < 1 || y > 9999) begin
        bad = 1'b1;
      end else begin
        cal_year  = y;
        cal_month = m;
        cal_day   = d;
      end
    end
    r.year  = 14'(cal_year);
    r.month = 4'(cal_month);
    r.day   = 5'(cal_day);
    r.wday  = day_of_week(cal_year, cal_month, cal_day);
    r.err   = bad;
    return r;
  endfunction

  function automatic int span_in(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly real dates and moderate spans, a few wide spans and raw noise
  function automatic date_op_t random_date_op();
    date_op_t op;
    int pick;
    int y;
    int m;
    op.ld_year   = 14'($urandom);
    op.ld_month  = 4'($urandom);
    op.ld_day    = 5'($urandom);
    op.sp_years  = 15'($urandom);
    op.sp_months = 13'($urandom);
    op.sp_days   = 17'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      op.kind = KindLoad;
      if (pick < 11) begin
        y = $urandom_range(1, 9999);
        m = $urandom_range(0, 11);
        op.ld_year  = 14'(y);
        op.ld_month = 4'(m);
        op.ld_day   = 5'($urandom_range(1, month_days(y, m)));
      end
    end else begin
      op.kind = KindAdd;
      pick = $urandom_range(0, 99);
      if (pick < 55) op.sp_years = '0;
      else if (pick < 80) op.sp_years = 15'(span_in(30));
      else if (pick < 92) op.sp_years = 15'(span_in(9999));
      pick = $urandom_range(0, 99);
      if (pick < 45) op.sp_months = '0;
      else if (pick < 80) op.sp_months = 13'(span_in(30));
      else if (pick < 92) op.sp_months = 13'(span_in(4095));
      pick = $urandom_range(0, 99);
      if (pick < 50) op.sp_days = 17'(span_in(400));
      else if (pick < 80) op.sp_days = 17'(span_in(5000));
      else if (pick < 92) op.sp_days = 17'(span_in(65535));
    end
    return op;
  endfunction

  task automatic issue_date_op(input date_op_t op, input logic typed,
                               input date_res_t typed_res);
    int gap;
    date_res_t want;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.kind;
    s_axis_tdata  <= {4'b0, op.sp_days, op.sp_months, op.sp_years,
                      op.ld_day, op.ld_month, op.ld_year};
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_date(op);
    expected_dates.push_back(typed ? typed_res : want);
    if (op.kind == KindLoad) n_loads++;
    else n_adds++;
    @(negedge clk_i);
  endtask

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  task automatic check_date_result();
    date_res_t want;
    if (expected_dates.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
               $time, m_axis_tdata, m_axis_tuser);
      n_fail++;
    end else begin
      want = expected_dates.pop_front();
      compare_field("date_year", want.year, m_axis_tdata[13:0]);
      compare_field("date_month", want.month, m_axis_tdata[17:14]);
      compare_field("date_day", want.day, m_axis_tdata[22:18]);
      compare_field("weekday", want.wday, m_axis_tdata[25:23]);
      compare_field("error", want.err, m_axis_tuser);
    end
    n_checked++;
    if (m_axis_tuser) n_rejects++;
  endtask

  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_date_result();
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, QuietLimit, expected_dates.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    date_op_t op;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    n_fail        = 0;
    n_loads       = 0;
    n_adds        = 0;
    n_checked     = 0;
    n_rejects     = 0;
    cal_year      = 1970;
    cal_month     = 0;
    cal_day       = 1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirPlan[i]) begin
      issue_date_op(DirPlan[i].op, DirPlan[i].typed, DirPlan[i].res);
    end

    for (int i = 0; i < NumRandom; i++) begin
      no_idle = (i % 500) >= 420;
      // hold off until the block has drained
      if (i % 400 == 200) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (expected_dates.size() != 0);
      end
      op = random_date_op();
      issue_date_op(op, 1'b0, NoRes);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d date loads and %0d span adds, directed edges and random spans.",
             n_loads, n_adds);
    $display("Checked %0d results, %0d of them rejected, %0d field mismatches.",
             n_checked, n_rejects, n_fail);
    if (n_fail == 0 && expected_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cdsa_pkg.sv
rtl/cdsa_ctrl.sv
rtl/cdsa_dpath.sv
rtl/calendar_date_span_adder_unit.sv
test/tb_calendar_date_span_adder_unit.sv
